/* sv/rlnc_enc_pkg.sv */
// Shared types, constants and the GF(2^8) multiply for the network coding encoder.
package rlnc_enc_pkg;

  localparam int BufferBytesDef = 2048;
  localparam int MaxPacketsDef  = 256;

  localparam logic [63:0] LcgMul   = 64'd6364136223846793005;
  localparam logic [63:0] LcgInc   = 64'd1442695040888963407;
  localparam logic [7:0]  GfReduce = 8'h1b;
  localparam logic [7:0]  PadMark  = 8'h80;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_SEED,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_PAD_RD,
    ST_PAD_WR,
    ST_RD_MEM,
    ST_RD_OUT
  } state_e;

  typedef enum logic [1:0] {
    MS_LO_LO,
    MS_LO_HI,
    MS_HI_LO
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_HI
  } acc_op_e;

  typedef struct packed {
    logic     start;
    logic     latch;
    logic     first_mark;
    logic     take_pkt;
    logic     clr_coeff;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     seed_upd;
    logic     set_coeff;
    logic     rd;
    logic     rd_idx;
    logic     wr;
    logic     pad;
    logic     pos_inc;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic pkt_avail;
    logic coeff_zero;
    logic seed_top_zero;
    logic pos_full;
    logic last;
    logic out_busy;
  } sts_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] a;
    acc = 8'h00;
    a   = x;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) acc = acc ^ a;
      a = a[7] ? ({a[6:0], 1'b0} ^ GfReduce) : {a[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

/* sv/rlnc_enc_ctrl.sv */
// Sequencing state machine of the network coding encoder.
module rlnc_enc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          action_i,
  input  logic                first_of_packet_i,
  output logic                in_stall_o,
  input  rlnc_enc_pkg::sts_t  sts_i,
  output rlnc_enc_pkg::cmd_t  cmd_o
);

  rlnc_enc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rlnc_enc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != rlnc_enc_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rlnc_enc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (action_i)
            rlnc_enc_pkg::ACT_DATA: begin
              if (first_of_packet_i) begin
                if (sts_i.pkt_avail) state_d = rlnc_enc_pkg::ST_MUL0;
              end else if (!sts_i.coeff_zero) begin
                state_d = rlnc_enc_pkg::ST_ACC_RD;
              end
            end
            rlnc_enc_pkg::ACT_READ: state_d = rlnc_enc_pkg::ST_RD_MEM;
            default: state_d = rlnc_enc_pkg::ST_IDLE;
          endcase
        end
      end
      rlnc_enc_pkg::ST_MUL0: state_d = rlnc_enc_pkg::ST_MUL1;
      rlnc_enc_pkg::ST_MUL1: state_d = rlnc_enc_pkg::ST_MUL2;
      rlnc_enc_pkg::ST_MUL2: state_d = rlnc_enc_pkg::ST_MUL3;
      rlnc_enc_pkg::ST_MUL3: state_d = rlnc_enc_pkg::ST_SEED;
      rlnc_enc_pkg::ST_SEED: begin
        state_d = sts_i.seed_top_zero ? rlnc_enc_pkg::ST_MUL0 : rlnc_enc_pkg::ST_ACC_RD;
      end
      rlnc_enc_pkg::ST_ACC_RD: begin
        if (!sts_i.pos_full) state_d = rlnc_enc_pkg::ST_ACC_WR;
        else state_d = sts_i.last ? rlnc_enc_pkg::ST_PAD_RD : rlnc_enc_pkg::ST_IDLE;
      end
      rlnc_enc_pkg::ST_ACC_WR: begin
        state_d = sts_i.last ? rlnc_enc_pkg::ST_PAD_RD : rlnc_enc_pkg::ST_IDLE;
      end
      rlnc_enc_pkg::ST_PAD_RD: begin
        state_d = sts_i.pos_full ? rlnc_enc_pkg::ST_IDLE : rlnc_enc_pkg::ST_PAD_WR;
      end
      rlnc_enc_pkg::ST_PAD_WR: state_d = rlnc_enc_pkg::ST_IDLE;
      rlnc_enc_pkg::ST_RD_MEM: state_d = rlnc_enc_pkg::ST_RD_OUT;
      rlnc_enc_pkg::ST_RD_OUT: begin
        if (!sts_i.out_busy) state_d = rlnc_enc_pkg::ST_IDLE;
      end
      default: state_d = rlnc_enc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = rlnc_enc_pkg::MS_LO_LO;
    cmd_o.acc_op  = rlnc_enc_pkg::ACC_HOLD;
    unique case (state_q)
      rlnc_enc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (action_i)
            rlnc_enc_pkg::ACT_START: cmd_o.start = 1'b1;
            rlnc_enc_pkg::ACT_DATA: begin
              cmd_o.latch = 1'b1;
              if (first_of_packet_i) begin
                cmd_o.first_mark = 1'b1;
                if (sts_i.pkt_avail) cmd_o.take_pkt = 1'b1;
                else cmd_o.clr_coeff = 1'b1;
              end
            end
            rlnc_enc_pkg::ACT_READ: cmd_o.latch = 1'b1;
            default: cmd_o.latch = 1'b0;
          endcase
        end
      end
      rlnc_enc_pkg::ST_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rlnc_enc_pkg::MS_LO_LO;
      end
      rlnc_enc_pkg::ST_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rlnc_enc_pkg::MS_LO_HI;
        cmd_o.acc_op  = rlnc_enc_pkg::ACC_LOAD;
      end
      rlnc_enc_pkg::ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rlnc_enc_pkg::MS_HI_LO;
        cmd_o.acc_op  = rlnc_enc_pkg::ACC_ADD_HI;
      end
      rlnc_enc_pkg::ST_MUL3: cmd_o.acc_op = rlnc_enc_pkg::ACC_ADD_HI;
      rlnc_enc_pkg::ST_SEED: begin
        cmd_o.seed_upd  = 1'b1;
        cmd_o.set_coeff = !sts_i.seed_top_zero;
      end
      rlnc_enc_pkg::ST_ACC_RD: cmd_o.rd = !sts_i.pos_full;
      rlnc_enc_pkg::ST_ACC_WR: begin
        cmd_o.wr      = 1'b1;
        cmd_o.pos_inc = 1'b1;
      end
      rlnc_enc_pkg::ST_PAD_RD: begin
        cmd_o.rd        = !sts_i.pos_full;
        cmd_o.clr_coeff = sts_i.pos_full;
      end
      rlnc_enc_pkg::ST_PAD_WR: begin
        cmd_o.wr        = 1'b1;
        cmd_o.pad       = 1'b1;
        cmd_o.clr_coeff = 1'b1;
      end
      rlnc_enc_pkg::ST_RD_MEM: begin
        cmd_o.rd     = 1'b1;
        cmd_o.rd_idx = 1'b1;
      end
      rlnc_enc_pkg::ST_RD_OUT: cmd_o.out_load = !sts_i.out_busy;
      default: cmd_o.out_load = 1'b0;
    endcase
  end

endmodule

/* sv/rlnc_enc_dp.sv */
// Datapath of the network coding encoder: generator, accumulator memory and output register.
module rlnc_enc_dp #(
  parameter int BUFFER_BYTES = rlnc_enc_pkg::BufferBytesDef,
  parameter int MAX_PACKETS  = rlnc_enc_pkg::MaxPacketsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rlnc_enc_pkg::cmd_t cmd_i,
  output rlnc_enc_pkg::sts_t sts_o,
  input  logic [31:0]        first_component_i,
  input  logic [8:0]         packet_count_i,
  input  logic [15:0]        nonce_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_of_packet_i,
  input  logic [10:0]        read_index_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [7:0]         coded_byte_o,
  output logic [11:0]        coded_length_o,
  output logic [63:0]        sequence_word_o,
  output logic               index_in_range_o
);

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int LW = $clog2(BUFFER_BYTES + 1);
  localparam int PW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS + 1) : 1;

  logic [7:0]    mem [BUFFER_BYTES];

  logic [63:0]   seed_q, seed_d;
  logic [7:0]    coeff_q, coeff_d;
  logic [LW-1:0] pos_q, pos_d;
  logic [LW-1:0] len_q, len_d;
  logic [PW-1:0] taken_q, taken_d;
  logic [PW-1:0] limit_q, limit_d;
  logic [63:0]   seq_q, seq_d;
  logic          out_valid_q, out_valid_d;

  logic [63:0]   prod_q;
  logic [63:0]   acc_q;
  logic [7:0]    data_q;
  logic          last_q;
  logic [10:0]   idx_q;
  logic [7:0]    rd_q;
  logic [7:0]    out_byte_q;
  logic [11:0]   out_len_q;
  logic [63:0]   out_seq_q;
  logic          out_inr_q;

  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [63:0]   seed_nxt;
  logic [31:0]   cnt32;
  logic [31:0]   seq_hi;
  logic [7:0]    gf_val;
  logic          in_len;
  logic [7:0]    wr_data;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          idx_inr;

  assign mul_a    = (cmd_i.mul_sel == rlnc_enc_pkg::MS_HI_LO) ? seed_q[63:32] : seed_q[31:0];
  assign mul_b    = (cmd_i.mul_sel == rlnc_enc_pkg::MS_LO_HI) ? rlnc_enc_pkg::LcgMul[63:32]
                                                               : rlnc_enc_pkg::LcgMul[31:0];
  assign prod     = mul_a * mul_b;
  assign seed_nxt = acc_q + rlnc_enc_pkg::LcgInc;

  assign cnt32  = (32'(packet_count_i) > 32'(MAX_PACKETS)) ? 32'(MAX_PACKETS)
                                                             : 32'(packet_count_i);
  assign seq_hi = cnt32 + {nonce_i, 16'h0000};

  assign gf_val  = rlnc_enc_pkg::gf_mul(cmd_i.pad ? rlnc_enc_pkg::PadMark : data_q, coeff_q);
  assign in_len  = (pos_q < len_q);
  assign wr_data = in_len ? (rd_q ^ gf_val) : gf_val;
  assign wr_addr = AW'(pos_q);
  assign rd_addr = cmd_i.rd_idx ? AW'(idx_q) : AW'(pos_q);
  assign idx_inr = (idx_q < len_q);

  always_comb begin
    seed_d      = seed_q;
    coeff_d     = coeff_q;
    pos_d       = pos_q;
    len_d       = len_q;
    taken_d     = taken_q;
    limit_d     = limit_q;
    seq_d       = seq_q;
    out_valid_d = out_valid_q;
    if (cmd_i.start) begin
      seq_d   = {seq_hi, first_component_i};
      seed_d  = {seq_hi, first_component_i};
      limit_d = PW'(cnt32);
      taken_d = '0;
      coeff_d = '0;
      pos_d   = '0;
      len_d   = '0;
    end
    if (cmd_i.first_mark) pos_d = '0;
    if (cmd_i.take_pkt) taken_d = taken_q + PW'(1);
    if (cmd_i.seed_upd) seed_d = seed_nxt;
    if (cmd_i.set_coeff) coeff_d = seed_nxt[63:56];
    if (cmd_i.clr_coeff) coeff_d = '0;
    if (cmd_i.wr && !in_len) len_d = pos_q + LW'(1);
    if (cmd_i.pos_inc) pos_d = pos_q + LW'(1);
    if (cmd_i.out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      coeff_q     <= '0;
      pos_q       <= '0;
      len_q       <= '0;
      taken_q     <= '0;
      limit_q     <= '0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seed_q      <= seed_d;
      coeff_q     <= coeff_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      taken_q     <= taken_d;
      limit_q     <= limit_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= prod;
    case (cmd_i.acc_op)
      rlnc_enc_pkg::ACC_LOAD:   acc_q <= prod_q;
      rlnc_enc_pkg::ACC_ADD_HI: acc_q <= {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
      default:                  acc_q <= acc_q;
    endcase
    if (cmd_i.latch) begin
      data_q <= data_byte_i;
      last_q <= last_of_packet_i;
      idx_q  <= read_index_i;
    end
    if (cmd_i.out_load) begin
      out_byte_q <= idx_inr ? rd_q : 8'h00;
      out_len_q  <= 12'(len_q);
      out_seq_q  <= seq_q;
      out_inr_q  <= idx_inr;
    end
  end

  // Accumulator memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) mem[wr_addr] <= wr_data;
    if (cmd_i.rd) rd_q <= mem[rd_addr];
  end

  assign sts_o.pkt_avail     = (taken_q < limit_q);
  assign sts_o.coeff_zero    = (coeff_q == 8'h00);
  assign sts_o.seed_top_zero = (seed_nxt[63:56] == 8'h00);
  assign sts_o.pos_full      = (pos_q >= LW'(BUFFER_BYTES));
  assign sts_o.last          = last_q;
  assign sts_o.out_busy      = out_valid_q && out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign coded_byte_o     = out_byte_q;
  assign coded_length_o   = out_len_q;
  assign sequence_word_o  = out_seq_q;
  assign index_in_range_o = out_inr_q;

endmodule

/* sv/rlnc_packet_encoder_gf256.sv */
// Top level of the random linear network coding encoder over GF(2^8).
//
// The block codes the packets of one generation into a single accumulator of
// BUFFER_BYTES bytes: a start transfer opens a generation and seeds a 64-bit
// linear congruential generator with the sequence word; each packet within the
// generation's count draws a nonzero coefficient from that generator on its
// first byte, every data byte is multiplied by it in GF(2^8) and XORed in at
// its position, and the last byte adds the padding marker times the
// coefficient just after it. A read transfer returns the coded byte at an
// index together with the coded length and the sequence word. Items are taken
// one at a time. A data byte passes through accept, memory read and memory
// write, and a last byte adds a padding read and write, because every update
// goes through the accumulator memory with a registered read. The first byte
// of a packet runs states MUL0 to MUL3 and SEED per draw of the generator
// (three 32x32 partial products on one shared multiplier, their sum, and the
// increment), repeated while the drawn byte is zero. A read passes through a
// memory read state and an output state that waits for a free output register,
// which holds the result for the consumer while the next item is already
// taken. The accumulator needs no clearing after reset: bytes at or beyond the
// coded length read as zero and are overwritten rather than XORed.
module rlnc_packet_encoder_gf256 #(
  parameter int BUFFER_BYTES = rlnc_enc_pkg::BufferBytesDef,
  parameter int MAX_PACKETS  = rlnc_enc_pkg::MaxPacketsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] first_component_i,
  input  logic [8:0]  packet_count_i,
  input  logic [15:0] nonce_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_packet_i,
  input  logic        last_of_packet_i,
  input  logic [10:0] read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  coded_byte_o,
  output logic [11:0] coded_length_o,
  output logic [63:0] sequence_word_o,
  output logic        index_in_range_o
);

  rlnc_enc_pkg::cmd_t cmd;
  rlnc_enc_pkg::sts_t sts;

  // The controller sees only the input handshake, the action and the first
  // mark; everything else reaches it as status from the datapath.
  rlnc_enc_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .action_i          (action_i),
    .first_of_packet_i (first_of_packet_i),
    .in_stall_o        (in_stall_o),
    .sts_i             (sts),
    .cmd_o             (cmd)
  );

  rlnc_enc_dp #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_PACKETS  (MAX_PACKETS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .first_component_i (first_component_i),
    .packet_count_i    (packet_count_i),
    .nonce_i           (nonce_i),
    .data_byte_i       (data_byte_i),
    .last_of_packet_i  (last_of_packet_i),
    .read_index_i      (read_index_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .coded_byte_o      (coded_byte_o),
    .coded_length_o    (coded_length_o),
    .sequence_word_o   (sequence_word_o),
    .index_in_range_o  (index_in_range_o)
  );

endmodule

/* sv/rlnc_enc_chk.sv */
// Port-level checker for the network coding encoder and its bind.
module rlnc_enc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  action_i,
  input logic [31:0] first_component_i,
  input logic [8:0]  packet_count_i,
  input logic [15:0] nonce_i,
  input logic [7:0]  data_byte_i,
  input logic        first_of_packet_i,
  input logic        last_of_packet_i,
  input logic [10:0] read_index_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  coded_byte_o,
  input logic [11:0] coded_length_o,
  input logic [63:0] sequence_word_o,
  input logic        index_in_range_o
);

  // After a start transfer the input is not stalled in the following cycle.
  a_start_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i == rlnc_enc_pkg::ACT_START |=> !in_stall_o)
    else $error("input still stalled after a start transfer");

  // A read with a free output register shows its result after the memory read and output states.
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i == rlnc_enc_pkg::ACT_READ && !out_valid_o
    |-> ##3 out_valid_o)
    else $error("read result did not appear in time");

  // Bytes outside the coded range read as zero.
  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !index_in_range_o |-> coded_byte_o == 8'h00)
    else $error("nonzero coded byte outside the coded range");

  // A held result keeps its sequence word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sequence_word_o))
    else $error("stalled result changed");

endmodule

bind rlnc_packet_encoder_gf256 rlnc_enc_chk u_chk (.*);

/* tb/sv/tb_rlnc_packet_encoder_gf256.sv */
// Self-checking testbench for the GF(2^8) network coding packet encoder.
`timescale 1ns / 100ps

module tb_rlnc_packet_encoder_gf256;

  localparam int ClkPeriod   = 8;
  localparam int ResetCycles = 9;
  localparam int BufBytes    = rlnc_enc_pkg::BufferBytesDef;
  localparam int MaxPkts     = rlnc_enc_pkg::MaxPacketsDef;
  localparam int RandomItems = 1900;
  localparam int StuckLimit  = 2000;
  localparam int DrainCycles = 16;
  localparam int ReportLimit = 10;

  // The action field has one code the block does not use; it must be ignored.
  localparam logic [1:0] ActUnused = 2'd3;

  // One input transfer. The hold flag keeps the sender back until every
  // read result that is already owed has been delivered.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] first_comp;
    logic [8:0]  pkt_count;
    logic [15:0] nonce;
    logic [7:0]  data;
    logic        first_mark;
    logic        last_mark;
    logic [10:0] rd_idx;
    logic        wait_drained;
  } stim_t;

  // What one read transfer must return.
  typedef struct packed {
    logic [7:0]  coded;
    logic [11:0] len;
    logic [63:0] seq;
    logic        in_range;
  } read_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = rlnc_enc_pkg::ACT_START;
  logic [31:0] first_component_i = '0;
  logic [8:0]  packet_count_i = '0;
  logic [15:0] nonce_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        first_of_packet_i = 1'b0;
  logic        last_of_packet_i = 1'b0;
  logic [10:0] read_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  coded_byte_o;
  logic [11:0] coded_length_o;
  logic [63:0] sequence_word_o;
  logic        index_in_range_o;

  rlnc_packet_encoder_gf256 uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .first_component_i (first_component_i),
    .packet_count_i    (packet_count_i),
    .nonce_i           (nonce_i),
    .data_byte_i       (data_byte_i),
    .first_of_packet_i (first_of_packet_i),
    .last_of_packet_i  (last_of_packet_i),
    .read_index_i      (read_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .coded_byte_o      (coded_byte_o),
    .coded_length_o    (coded_length_o),
    .sequence_word_o   (sequence_word_o),
    .index_in_range_o  (index_in_range_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Transfers waiting to be offered, and read results owed by the block.
  stim_t        items_q[$];
  read_result_t pending_reads[$];

  // Shadow copy of the encoder state, updated when a transfer is accepted.
  logic [7:0]  acc_mem [0:BufBytes-1];
  logic [63:0] lcg_state = '0;
  logic [7:0]  coeff_now = 8'h00;
  int          write_pos = 0;
  int          acc_len = 0;
  int          pkts_used = 0;
  int          pkts_allowed = 0;
  logic [63:0] seq_word = '0;

  int items_built = 0;
  int items_sent = 0;
  int reads_checked = 0;
  int gen_count = 0;
  int fail_count = 0;
  int stuck_cycles;

  // Multiplication in GF(2^8) with the AES reduction polynomial, shift and add.
  function automatic logic [7:0] gf256_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] prod;
    logic [7:0] m;
    logic [7:0] n;
    prod = 8'h00;
    m    = a;
    n    = b;
    while (n != 8'h00) begin
      if (n[0]) prod = prod ^ m;
      m = {m[6:0], 1'b0} ^ (m[7] ? rlnc_enc_pkg::GfReduce : 8'h00);
      n = n >> 1;
    end
    return prod;
  endfunction

  // Bytes at or beyond the coded length count as zero, so a write there
  // replaces the old content and extends the length. Past the buffer the
  // byte is simply lost.
  task fold_byte(input int pos, input logic [7:0] v);
    if (pos < BufBytes) begin
      if (pos < acc_len) begin
        acc_mem[pos] = acc_mem[pos] ^ v;
      end else begin
        acc_mem[pos] = v;
        acc_len      = pos + 1;
      end
    end
  endtask

  // Applies one accepted transfer to the shadow state. A read pushes the
  // result the block must return for it.
  task encode_item(input stim_t it);
    logic [8:0]   cnt;
    logic         inr;
    read_result_t r;
    if (it.action == rlnc_enc_pkg::ACT_START) begin
      cnt = (it.pkt_count > MaxPkts) ? 9'(MaxPkts) : it.pkt_count;
      seq_word = {32'h0, it.first_comp} + {23'h0, cnt, 32'h0} + {it.nonce, 48'h0};
      lcg_state    = seq_word;
      pkts_allowed = int'(cnt);
      pkts_used    = 0;
      coeff_now    = 8'h00;
      write_pos    = 0;
      acc_len      = 0;
    end else if (it.action == rlnc_enc_pkg::ACT_DATA) begin
      if (it.first_mark) begin
        // A first mark always closes the open packet; a new coefficient is
        // drawn only while the generation still has room for packets.
        coeff_now = 8'h00;
        if (pkts_used < pkts_allowed) begin
          while (coeff_now == 8'h00) begin
            lcg_state = lcg_state * rlnc_enc_pkg::LcgMul + rlnc_enc_pkg::LcgInc;
            coeff_now = lcg_state[63:56];
          end
          pkts_used++;
        end
        write_pos = 0;
      end
      if (coeff_now != 8'h00) begin
        fold_byte(write_pos, gf256_times(it.data, coeff_now));
        if (write_pos < BufBytes) write_pos++;
        if (it.last_mark) begin
          fold_byte(write_pos, gf256_times(rlnc_enc_pkg::PadMark, coeff_now));
          coeff_now = 8'h00;
        end
      end
    end else if (it.action == rlnc_enc_pkg::ACT_READ) begin
      inr        = (it.rd_idx < acc_len);
      r.coded    = inr ? acc_mem[it.rd_idx] : 8'h00;
      r.len      = acc_len[11:0];
      r.seq      = seq_word;
      r.in_range = inr;
      pending_reads.push_back(r);
    end
  endtask

  // Unused fields of every transfer carry random values as well.
  function automatic stim_t blank_item();
    stim_t it;
    it.action       = rlnc_enc_pkg::ACT_READ;
    it.first_comp   = $urandom;
    it.pkt_count    = 9'($urandom_range(0, 511));
    it.nonce        = 16'($urandom_range(0, 65535));
    it.data         = 8'($urandom_range(0, 255));
    it.first_mark   = 1'($urandom_range(0, 1));
    it.last_mark    = 1'($urandom_range(0, 1));
    it.rd_idx       = 11'($urandom_range(0, 2047));
    it.wait_drained = 1'b0;
    return it;
  endfunction

  task queue_start(input logic [31:0] first, input logic [8:0] count, input logic [15:0] nonce);
    stim_t it;
    it            = blank_item();
    it.action     = rlnc_enc_pkg::ACT_START;
    it.first_comp = first;
    it.pkt_count  = count;
    it.nonce      = nonce;
    items_q.push_back(it);
    items_built++;
    gen_count++;
  endtask

  task queue_byte(input logic [7:0] d, input logic f, input logic l);
    stim_t it;
    it            = blank_item();
    it.action     = rlnc_enc_pkg::ACT_DATA;
    it.data       = d;
    it.first_mark = f;
    it.last_mark  = l;
    items_q.push_back(it);
    items_built++;
  endtask

  task queue_read(input logic [10:0] idx, input logic hold);
    stim_t it;
    it              = blank_item();
    it.action       = rlnc_enc_pkg::ACT_READ;
    it.rd_idx       = idx;
    it.wait_drained = hold;
    items_q.push_back(it);
    items_built++;
  endtask

  // Either the unused action code, or a data byte without marks, which the
  // block drops when no packet is open.
  task queue_noise();
    stim_t it;
    it = blank_item();
    if ($urandom_range(0, 1) == 0) begin
      it.action = ActUnused;
    end else begin
      it.action     = rlnc_enc_pkg::ACT_DATA;
      it.first_mark = 1'b0;
      it.last_mark  = 1'b0;
    end
    items_q.push_back(it);
    items_built++;
  endtask

  // A packet of len bytes with random content. Without the last mark it
  // stays open until the next first mark ends it without padding.
  task queue_packet(input int len, input bit with_last);
    for (int i = 0; i < len; i++) begin
      queue_byte(8'($urandom_range(0, 255)), i == 0, with_last && (i == len - 1));
    end
  endtask

  // Sender: offers the head of items_q, waits a random number of cycles
  // between transfers, and holds back flagged items until all owed reads
  // have come out.
  stim_t cur_item;
  int    send_gap;
  int    send_wait;
  bit    send_calm = 1'b0;

  function automatic int pick_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic bit ready_to_send();
    if (items_q.size() == 0) return 1'b0;
    return !items_q[0].wait_drained || (pending_reads.size() == 0);
  endfunction

  task present_next();
    cur_item          = items_q.pop_front();
    in_valid_i        <= 1'b1;
    action_i          <= cur_item.action;
    first_component_i <= cur_item.first_comp;
    packet_count_i    <= cur_item.pkt_count;
    nonce_i           <= cur_item.nonce;
    data_byte_i       <= cur_item.data;
    first_of_packet_i <= cur_item.first_mark;
    last_of_packet_i  <= cur_item.last_mark;
    read_index_i      <= cur_item.rd_idx;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait  <= 0;
    end else if (in_valid_i && !in_stall_o) begin
      // The transfer completes here: update the shadow state, then either
      // keep valid high with the next item or open a gap.
      encode_item(cur_item);
      items_sent++;
      if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
      send_gap = pick_wait(send_calm);
      if (send_gap == 0 && ready_to_send()) begin
        present_next();
      end else begin
        in_valid_i <= 1'b0;
        send_wait  <= send_gap;
      end
    end else if (!in_valid_i) begin
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
      end else if (ready_to_send()) begin
        present_next();
      end
    end
  end

  // Receiver: after each result transfer it stalls the following result for
  // a random number of cycles, so stalls land on every phase of a read.
  int recv_gap;
  int stall_left;
  bit recv_calm = 1'b0;

  task check_read();
    read_result_t want;
    if (pending_reads.size() == 0) begin
      fail_count++;
      if (fail_count <= ReportLimit) begin
        $display("unexpected read result: byte %02h len %0d seq %016h in_range %0b",
                 coded_byte_o, coded_length_o, sequence_word_o, index_in_range_o);
      end
    end else begin
      want = pending_reads.pop_front();
      reads_checked++;
      if (coded_byte_o !== want.coded || coded_length_o !== want.len ||
          sequence_word_o !== want.seq || index_in_range_o !== want.in_range) begin
        fail_count++;
        if (fail_count <= ReportLimit) begin
          $display("read %0d mismatch: expected byte %02h len %0d seq %016h in_range %0b",
                   reads_checked, want.coded, want.len, want.seq, want.in_range);
          $display("               got      byte %02h len %0d seq %016h in_range %0b",
                   coded_byte_o, coded_length_o, sequence_word_o, index_in_range_o);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      check_read();
      if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
      recv_gap = pick_wait(recv_calm);
      stall_left  <= recv_gap;
      out_stall_i <= (recv_gap != 0);
    end else if (out_valid_o && out_stall_i) begin
      if (stall_left <= 1) begin
        stall_left  <= 0;
        out_stall_i <= 1'b0;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // Cycles in a row in which neither channel moved a transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stuck_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < StuckLimit) @(posedge clk_i);
    $display("no transfer for %0d cycles, %0d items unsent, %0d read results owed",
             StuckLimit, items_q.size(), pending_reads.size());
    $display("tb_rlnc_packet_encoder_gf256: FAIL");
    $finish;
  end

  int n_pk;
  int pkt_len;
  int span;
  int cnt_pick;

  initial begin
    // Directed part. A read straight after reset sees an empty buffer and a
    // zero sequence word.
    queue_read(11'd0, 1'b0);
    // All-ones first component and nonce with the largest legal count.
    queue_start(32'hffff_ffff, 9'd256, 16'hffff);
    // A one-byte packet carries both marks: the byte plus its padding.
    queue_byte(8'hff, 1'b1, 1'b1);
    queue_read(11'd0, 1'b0);
    queue_read(11'd1, 1'b0);
    queue_read(11'd2, 1'b0);
    // A byte after the last mark has no open packet and is dropped.
    queue_byte(8'h55, 1'b0, 1'b0);
    // A packet left open is ended by the next first mark, without padding.
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'h01, 1'b0, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'haa, 1'b1, 1'b0);
    queue_byte(8'h7f, 1'b0, 1'b1);
    queue_noise();
    queue_read(11'd2, 1'b1);
    queue_read(11'd2047, 1'b0);
    // A zero packet count takes no packet at all.
    queue_start(32'h0, 9'd0, 16'h0001);
    queue_byte(8'h12, 1'b1, 1'b1);
    queue_read(11'd0, 1'b0);
    // Counts above the maximum are clamped, in the sequence word as well.
    queue_start($urandom, 9'd511, 16'h0000);
    queue_read(11'd0, 1'b1);

    // Random part: generations of short packets, some counts smaller than
    // the packets sent, some packets left open, reads around the coded end.
    while (items_built < RandomItems) begin
      cnt_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 6);
      queue_start($urandom, 9'(cnt_pick),
                  ($urandom_range(0, 31) == 0) ? 16'h0 : 16'($urandom_range(1, 65535)));
      n_pk = (cnt_pick > 6) ? $urandom_range(1, 8) : cnt_pick + $urandom_range(0, 2);
      span = 0;
      for (int p = 0; p < n_pk; p++) begin
        pkt_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        queue_packet(pkt_len, $urandom_range(0, 7) != 0);
        if (pkt_len + 1 > span) span = pkt_len + 1;
        if ($urandom_range(0, 5) == 0) queue_noise();
        for (int r = $urandom_range(1, 3); r > 0; r--) begin
          queue_read(11'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) :
                         $urandom_range(0, span + 2)), $urandom_range(0, 39) == 0);
        end
      end
    end

    // A last sweep of reads over the whole index range once all is drained.
    queue_read(11'd0, 1'b1);
    for (int r = 0; r < 8; r++) queue_read(11'($urandom_range(0, 2047)), 1'b0);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_q.size() != 0 || in_valid_i || pending_reads.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d input transfers over %0d generations, with open packets and clamped counts",
             items_sent, gen_count);
    $display("%0d read results checked, %0d mismatches", reads_checked, fail_count);
    if (fail_count == 0 && pending_reads.size() == 0) begin
      $display("tb_rlnc_packet_encoder_gf256: PASS");
    end else begin
      $display("tb_rlnc_packet_encoder_gf256: FAIL");
    end
    $finish;
  end

endmodule
